FILE: rtl/core/lslf_pkg.sv
package lslf_pkg;

    localparam int MAX_POINTS = 65536;

    localparam int COORD_W  = 24;
    localparam int COUNT_W  = 17;
    localparam int SLOPE_W  = 32;
    localparam int ICPT_W   = 24;
    localparam int SUMX_W   = 41;
    localparam int SUMXX_W  = 63;
    localparam int SUMXY_W  = 64;
    localparam int PROD_W   = COORD_W + SLOPE_W;
    localparam int PT_W     = PROD_W + 2;
    localparam int ACC_W    = 128;
    localparam int MUL_B_W  = SUMX_W + 1;
    localparam int MUL_STEPS = MUL_B_W;
    localparam int DIV_STEPS = ACC_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);
    localparam int TERM_W   = 3;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 104;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ACCUM  = 2'd1,
        OP_FINISH = 2'd2,
        OP_POINT  = 2'd3
    } op_t;

    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    localparam logic [TERM_W-1:0] TERM_DEN_A = 3'd0;
    localparam logic [TERM_W-1:0] TERM_DEN_B = 3'd1;
    localparam logic [TERM_W-1:0] TERM_KN_A  = 3'd2;
    localparam logic [TERM_W-1:0] TERM_KN_B  = 3'd3;
    localparam logic [TERM_W-1:0] TERM_BN_A  = 3'd4;
    localparam logic [TERM_W-1:0] TERM_BN_B  = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC0,
        ST_ACC1,
        ST_ACC2,
        ST_PT_MUL,
        ST_PT_RND,
        ST_TERM_LOAD,
        ST_MUL_STEP,
        ST_CHK_DEN,
        ST_NEG,
        ST_LOAD_DIV,
        ST_DIV_STEP,
        ST_ROUND,
        ST_INC,
        ST_SAT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             inv;
        logic             cin;
    } alu_req_t;

    typedef struct packed {
        logic             carry;
        logic [ACC_W-1:0] sum;
    } alu_rsp_t;

    // divide by 2^16, round half away from zero, saturate to 24 bits
    function automatic logic [ICPT_W-1:0] round_sat24(input logic [PT_W-1:0] v);
        logic [PT_W-1:0]    mag;
        logic [PT_W-1:0]    rnd;
        logic [PT_W-17:0]   m;
        logic [ICPT_W-1:0]  res;
        mag = v[PT_W-1] ? (PT_W'(0) - v) : v;
        rnd = mag + PT_W'(32768);
        m   = rnd[PT_W-1:16];
        if (v[PT_W-1]) begin
            if (m > (PT_W-16)'(24'h800000)) begin
                res = 24'h800000;
            end else begin
                res = 24'(0) - m[ICPT_W-1:0];
            end
        end else begin
            if (m > (PT_W-16)'(24'h7FFFFF)) begin
                res = 24'h7FFFFF;
            end else begin
                res = m[ICPT_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/least_squares_line_fit_unit.sv
// least squares line fit y = k*x + b
// input stream: s_tuser carries the operation (clear, add point, finish, fit point),
// s_tdata carries x and y in signed q16.8
// output stream: m_tuser is the result kind (0 line, 1 fitted point), m_tdata the fields
// clear and add point give no transaction on the output
// one item at a time: s_tready is high only while the sequencer is idle
// clear is done in the idle state; add point runs through ACC0, ACC1 and ACC2
// (one 24x32 multiplier used twice); fit point multiplies, then rounds, and skips both
// when the stored line is degenerate; finish sends six 128x42 products (two when the fit
// is degenerate) through one shared 128-bit adder bit by bit, then two restoring
// divisions of 128 steps each on the same adder, plus rounding and saturation
// a result is valid on the output as the sequencer returns to idle
// results sit in an output register; while the receiver stalls a finished result
// waits there and the sequencer holds before loading the next one
// reset clears the sums and the count, zeroes the stored line and marks it degenerate
module least_squares_line_fit_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lslf_pkg::IN_W-1:0]    s_tdata,  // x_coord, y_coord
    input  logic [1:0]                   s_tuser,  // op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lslf_pkg::OUT_W-1:0]   m_tdata,  // slope, intercept, degenerate,
                                                   // point_count, overflowed, fitted_y
    output logic [0:0]                   m_tuser   // kind
);

    lslf_pkg::state_t state_reg, state_next;

    logic [lslf_pkg::TERM_W-1:0]  term_reg, term_next;
    logic [lslf_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic [lslf_pkg::COORD_W-1:0] x_reg, x_next;
    logic [lslf_pkg::COORD_W-1:0] y_reg, y_next;
    logic [lslf_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [lslf_pkg::SUMX_W-1:0]  sum_x_reg, sum_x_next;
    logic [lslf_pkg::SUMX_W-1:0]  sum_y_reg, sum_y_next;
    logic [lslf_pkg::SUMXX_W-1:0] sum_xx_reg, sum_xx_next;
    logic [lslf_pkg::SUMXY_W-1:0] sum_xy_reg, sum_xy_next;
    logic [lslf_pkg::SLOPE_W-1:0] slope_reg, slope_next;
    logic [lslf_pkg::ICPT_W-1:0]  icpt_reg, icpt_next;
    logic                         deg_reg, deg_next;
    logic                         ovf_reg, ovf_next;
    logic [lslf_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [lslf_pkg::ACC_W-1:0]   num_reg, num_next;
    logic [lslf_pkg::ACC_W-1:0]   d_reg, d_next;
    logic [lslf_pkg::MUL_B_W-1:0] b_reg, b_next;
    logic                         neg_reg, neg_next;
    logic                         rnd_reg, rnd_next;
    logic [lslf_pkg::ICPT_W-1:0]  fitted_reg, fitted_next;
    logic                         kind_reg, kind_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [lslf_pkg::OUT_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                         m_tuser_reg, m_tuser_next;

    logic [lslf_pkg::COORD_W-1:0] mul_a;
    logic [lslf_pkg::SLOPE_W-1:0] mul_b;
    logic [lslf_pkg::PROD_W-1:0]  mul_p;
    logic [lslf_pkg::PT_W-1:0]    pt_sum;
    lslf_pkg::alu_req_t           alu_req;
    lslf_pkg::alu_rsp_t           alu_rsp;
    logic                         in_accept;
    logic                         mul_neg;
    logic                         sat_pos32, sat_neg32, sat_pos24, sat_neg24;
    logic [lslf_pkg::SLOPE_W-1:0] slope_sat;
    logic [lslf_pkg::ICPT_W-1:0]  icpt_sat;

    lslf_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    lslf_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_tready  = (state_reg == lslf_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign mul_a  = x_reg;
    assign pt_sum = {{2{mul_p[lslf_pkg::PROD_W-1]}}, mul_p}
                  + {{18{icpt_reg[lslf_pkg::ICPT_W-1]}}, icpt_reg, 16'b0};

    always_comb
    begin
        unique case (state_reg)
            lslf_pkg::ST_ACC1:   mul_b = {{8{y_reg[lslf_pkg::COORD_W-1]}}, y_reg};
            lslf_pkg::ST_PT_MUL: mul_b = slope_reg;
            default:             mul_b = {{8{x_reg[lslf_pkg::COORD_W-1]}}, x_reg};
        endcase
    end

    // quotient saturation checks
    assign sat_pos32 = |num_reg[lslf_pkg::ACC_W-1:31];
    assign sat_neg32 = (|num_reg[lslf_pkg::ACC_W-1:32]) || (num_reg[31] && |num_reg[30:0]);
    assign sat_pos24 = |num_reg[lslf_pkg::ACC_W-1:23];
    assign sat_neg24 = (|num_reg[lslf_pkg::ACC_W-1:24]) || (num_reg[23] && |num_reg[22:0]);

    always_comb
    begin
        if (neg_reg)
        begin
            slope_sat = sat_neg32 ? 32'h80000000 : (32'(0) - num_reg[31:0]);
            icpt_sat  = sat_neg24 ? 24'h800000 : (24'(0) - num_reg[23:0]);
        end
        else
        begin
            slope_sat = sat_pos32 ? 32'h7FFFFFFF : num_reg[31:0];
            icpt_sat  = sat_pos24 ? 24'h7FFFFF : num_reg[23:0];
        end
    end

    assign mul_neg = term_reg[0] ^ (cnt_reg == lslf_pkg::STEP_W'(lslf_pkg::MUL_STEPS - 1));

    always_comb
    begin
        unique case (state_reg)
            lslf_pkg::ST_MUL_STEP:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = b_reg[0] ? num_reg : '0;
                alu_req.inv = b_reg[0] & mul_neg;
                alu_req.cin = b_reg[0] & mul_neg;
            end
            lslf_pkg::ST_NEG:
            begin
                alu_req.a   = '0;
                alu_req.b   = acc_reg;
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
            end
            lslf_pkg::ST_DIV_STEP:
            begin
                alu_req.a   = {acc_reg[lslf_pkg::ACC_W-2:0], num_reg[lslf_pkg::ACC_W-1]};
                alu_req.b   = d_reg;
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
            end
            lslf_pkg::ST_ROUND:
            begin
                alu_req.a   = {acc_reg[lslf_pkg::ACC_W-2:0], 1'b0};
                alu_req.b   = d_reg;
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
            end
            default:
            begin
                alu_req.a   = num_reg;
                alu_req.b   = '0;
                alu_req.inv = 1'b0;
                alu_req.cin = rnd_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        term_next     = term_reg;
        cnt_next      = cnt_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        count_next    = count_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        sum_xx_next   = sum_xx_reg;
        sum_xy_next   = sum_xy_reg;
        slope_next    = slope_reg;
        icpt_next     = icpt_reg;
        deg_next      = deg_reg;
        ovf_next      = ovf_reg;
        acc_next      = acc_reg;
        num_next      = num_reg;
        d_next        = d_reg;
        b_next        = b_reg;
        neg_next      = neg_reg;
        rnd_next      = rnd_reg;
        fitted_next   = fitted_reg;
        kind_next     = kind_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            lslf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    x_next = s_tdata[23:0];
                    y_next = s_tdata[47:24];
                    unique case (lslf_pkg::op_t'(s_tuser))
                        lslf_pkg::OP_CLEAR:
                        begin
                            count_next  = '0;
                            sum_x_next  = '0;
                            sum_y_next  = '0;
                            sum_xx_next = '0;
                            sum_xy_next = '0;
                            ovf_next    = 1'b0;
                        end
                        lslf_pkg::OP_ACCUM:
                        begin
                            if (count_reg >= lslf_pkg::COUNT_W'(lslf_pkg::MAX_POINTS))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                state_next = lslf_pkg::ST_ACC0;
                            end
                        end
                        lslf_pkg::OP_FINISH:
                        begin
                            term_next  = lslf_pkg::TERM_DEN_A;
                            state_next = lslf_pkg::ST_TERM_LOAD;
                        end
                        lslf_pkg::OP_POINT:
                        begin
                            kind_next = lslf_pkg::KIND_POINT;
                            if (deg_reg)
                            begin
                                fitted_next = s_tdata[47:24];
                                state_next  = lslf_pkg::ST_OUT;
                            end
                            else
                            begin
                                state_next = lslf_pkg::ST_PT_MUL;
                            end
                        end
                    endcase
                end
            end
            lslf_pkg::ST_ACC0:
            begin
                count_next = count_reg + 1'b1;
                sum_x_next = sum_x_reg + {{17{x_reg[lslf_pkg::COORD_W-1]}}, x_reg};
                sum_y_next = sum_y_reg + {{17{y_reg[lslf_pkg::COORD_W-1]}}, y_reg};
                state_next = lslf_pkg::ST_ACC1;
            end
            lslf_pkg::ST_ACC1:
            begin
                sum_xx_next = sum_xx_reg + {16'b0, mul_p[46:0]};
                state_next  = lslf_pkg::ST_ACC2;
            end
            lslf_pkg::ST_ACC2:
            begin
                sum_xy_next = sum_xy_reg + {{16{mul_p[47]}}, mul_p[47:0]};
                state_next  = lslf_pkg::ST_IDLE;
            end
            lslf_pkg::ST_PT_MUL:
            begin
                state_next = lslf_pkg::ST_PT_RND;
            end
            lslf_pkg::ST_PT_RND:
            begin
                fitted_next = lslf_pkg::round_sat24(pt_sum);
                state_next  = lslf_pkg::ST_OUT;
            end
            lslf_pkg::ST_TERM_LOAD:
            begin
                if (!term_reg[0])
                begin
                    acc_next = '0;
                end
                cnt_next = '0;
                case (term_reg)
                    lslf_pkg::TERM_DEN_A:
                    begin
                        num_next = {65'b0, sum_xx_reg};
                        b_next   = {25'b0, count_reg};
                    end
                    lslf_pkg::TERM_DEN_B:
                    begin
                        num_next = {{87{sum_x_reg[40]}}, sum_x_reg};
                        b_next   = {sum_x_reg[40], sum_x_reg};
                    end
                    lslf_pkg::TERM_KN_A:
                    begin
                        num_next = {{64{sum_xy_reg[63]}}, sum_xy_reg};
                        b_next   = {25'b0, count_reg};
                    end
                    lslf_pkg::TERM_KN_B:
                    begin
                        num_next = {{87{sum_y_reg[40]}}, sum_y_reg};
                        b_next   = {sum_x_reg[40], sum_x_reg};
                    end
                    lslf_pkg::TERM_BN_A:
                    begin
                        num_next = {65'b0, sum_xx_reg};
                        b_next   = {sum_y_reg[40], sum_y_reg};
                    end
                    lslf_pkg::TERM_BN_B:
                    begin
                        num_next = {{64{sum_xy_reg[63]}}, sum_xy_reg};
                        b_next   = {sum_x_reg[40], sum_x_reg};
                    end
                    default:
                    begin
                        num_next = '0;
                        b_next   = '0;
                    end
                endcase
                state_next = lslf_pkg::ST_MUL_STEP;
            end
            lslf_pkg::ST_MUL_STEP:
            begin
                acc_next = alu_rsp.sum;
                num_next = {num_reg[lslf_pkg::ACC_W-2:0], 1'b0};
                b_next   = {1'b0, b_reg[lslf_pkg::MUL_B_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lslf_pkg::STEP_W'(lslf_pkg::MUL_STEPS - 1))
                begin
                    if (!term_reg[0])
                    begin
                        term_next  = term_reg + 1'b1;
                        state_next = lslf_pkg::ST_TERM_LOAD;
                    end
                    else if (term_reg == lslf_pkg::TERM_DEN_B)
                    begin
                        state_next = lslf_pkg::ST_CHK_DEN;
                    end
                    else
                    begin
                        state_next = lslf_pkg::ST_NEG;
                    end
                end
            end
            lslf_pkg::ST_CHK_DEN:
            begin
                d_next = acc_reg;
                if (acc_reg == '0)
                begin
                    deg_next   = 1'b1;
                    slope_next = '0;
                    icpt_next  = '0;
                    kind_next  = lslf_pkg::KIND_LINE;
                    state_next = lslf_pkg::ST_OUT;
                end
                else
                begin
                    term_next  = lslf_pkg::TERM_KN_A;
                    state_next = lslf_pkg::ST_TERM_LOAD;
                end
            end
            lslf_pkg::ST_NEG:
            begin
                neg_next = acc_reg[lslf_pkg::ACC_W-1];
                if (acc_reg[lslf_pkg::ACC_W-1])
                begin
                    acc_next = alu_rsp.sum;
                end
                state_next = lslf_pkg::ST_LOAD_DIV;
            end
            lslf_pkg::ST_LOAD_DIV:
            begin
                num_next   = (term_reg == lslf_pkg::TERM_KN_B)
                           ? {acc_reg[lslf_pkg::ACC_W-17:0], 16'b0} : acc_reg;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = lslf_pkg::ST_DIV_STEP;
            end
            lslf_pkg::ST_DIV_STEP:
            begin
                acc_next = alu_rsp.carry ? alu_rsp.sum : alu_req.a;
                num_next = {num_reg[lslf_pkg::ACC_W-2:0], alu_rsp.carry};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lslf_pkg::STEP_W'(lslf_pkg::DIV_STEPS - 1))
                begin
                    state_next = lslf_pkg::ST_ROUND;
                end
            end
            lslf_pkg::ST_ROUND:
            begin
                rnd_next   = alu_rsp.carry;
                state_next = lslf_pkg::ST_INC;
            end
            lslf_pkg::ST_INC:
            begin
                num_next   = alu_rsp.sum;
                state_next = lslf_pkg::ST_SAT;
            end
            lslf_pkg::ST_SAT:
            begin
                if (term_reg == lslf_pkg::TERM_KN_B)
                begin
                    slope_next = slope_sat;
                    term_next  = lslf_pkg::TERM_BN_A;
                    state_next = lslf_pkg::ST_TERM_LOAD;
                end
                else
                begin
                    icpt_next  = icpt_sat;
                    deg_next   = 1'b0;
                    kind_next  = lslf_pkg::KIND_LINE;
                    state_next = lslf_pkg::ST_OUT;
                end
            end
            lslf_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = kind_reg;
                    if (kind_reg == lslf_pkg::KIND_POINT)
                    begin
                        m_tdata_next = {5'b0, fitted_reg, 1'b0, 17'b0, deg_reg, 24'b0, 32'b0};
                    end
                    else
                    begin
                        m_tdata_next = {5'b0, 24'b0, ovf_reg, count_reg, deg_reg,
                                        icpt_reg, slope_reg};
                    end
                    state_next = lslf_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lslf_pkg::ST_IDLE;
            term_reg     <= '0;
            cnt_reg      <= '0;
            count_reg    <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_xx_reg   <= '0;
            sum_xy_reg   <= '0;
            slope_reg    <= '0;
            icpt_reg     <= '0;
            deg_reg      <= 1'b1;
            ovf_reg      <= 1'b0;
            kind_reg     <= lslf_pkg::KIND_LINE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            term_reg     <= term_next;
            cnt_reg      <= cnt_next;
            count_reg    <= count_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            sum_xx_reg   <= sum_xx_next;
            sum_xy_reg   <= sum_xy_next;
            slope_reg    <= slope_next;
            icpt_reg     <= icpt_next;
            deg_reg      <= deg_next;
            ovf_reg      <= ovf_next;
            kind_reg     <= kind_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        acc_reg     <= acc_next;
        num_reg     <= num_next;
        d_reg       <= d_next;
        b_reg       <= b_next;
        neg_reg     <= neg_next;
        rnd_reg     <= rnd_next;
        fitted_reg  <= fitted_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

FILE: rtl/core/lslf_mul.sv
module lslf_mul (
    input  logic                                clk,
    input  logic signed [lslf_pkg::COORD_W-1:0] a,
    input  logic signed [lslf_pkg::SLOPE_W-1:0] b,
    output logic signed [lslf_pkg::PROD_W-1:0]  p_reg
);

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

FILE: rtl/core/lslf_alu.sv
module lslf_alu (
    input  lslf_pkg::alu_req_t req,
    output lslf_pkg::alu_rsp_t rsp
);

    logic [lslf_pkg::ACC_W-1:0] b_sel;

    assign b_sel = req.inv ? ~req.b : req.b;
    assign {rsp.carry, rsp.sum} = {1'b0, req.a} + {1'b0, b_sel}
                                  + (lslf_pkg::ACC_W + 1)'(req.cin);

endmodule

FILE: tb/tb.sv
module tb;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int PTS_CAP = 65536;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic        kind;
        longint      slope;
        longint      intercept;
        logic        degenerate;
        longint      point_count;
        logic        overflowed;
        longint      fitted_y;
    } fit_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [lslf_pkg::IN_W-1:0]    s_tdata;
    logic [1:0]                   s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [lslf_pkg::OUT_W-1:0]   m_tdata;
    logic [0:0]                   m_tuser;

    // fitter state as the block should hold it
    int          pts;
    longint      acc_x, acc_y, acc_xx, acc_xy;
    longint      line_k, line_b;
    logic        line_degen, pts_dropped;

    fit_result_t expected_fits[$];
    int          errors;
    longint      cycles;
    int          lines_seen, points_seen;
    bit          send_gaps;
    bit          recv_gaps;
    int          hold_cycles;

    least_squares_line_fit_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // rounded quotient, ties away from zero, saturated to [lo, hi]
    function automatic longint div_round_sat(wide_t num, wide_t den, longint lo, longint hi);
        logic [127:0] a;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] r;
        logic         neg;
        neg = (num < 0) != (den < 0);
        a = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = a / d;
        r = a % d;
        if ((r << 1) >= d)
        begin
            q = q + 1;
        end
        if (neg)
        begin
            if (q > 128'(-lo))
            begin
                return lo;
            end
            return -longint'(q);
        end
        if (q > 128'(hi))
        begin
            return hi;
        end
        return longint'(q);
    endfunction

    function automatic longint scale_round_sat24(longint v);
        longint m;
        m = ((v < 0 ? -v : v) + 32768) >>> 16;
        if (v < 0)
        begin
            return (m > 64'h800000) ? -64'sh800000 : -m;
        end
        return (m > 64'h7FFFFF) ? 64'sh7FFFFF : m;
    endfunction

    function automatic void fitter_reset();
        pts = 0;
        acc_x = 0;
        acc_y = 0;
        acc_xx = 0;
        acc_xy = 0;
        line_k = 0;
        line_b = 0;
        line_degen = 1'b1;
        pts_dropped = 1'b0;
    endfunction

    // advance the fitter by one transaction, queue the result it gives
    function automatic void fitter_apply(lslf_pkg::op_t op, logic signed [23:0] xc,
                                         logic signed [23:0] yc);
        fit_result_t res;
        longint      x;
        longint      y;
        wide_t       n;
        wide_t       den;
        wide_t       kn;
        wide_t       bn;
        x = xc;
        y = yc;
        res = '{default: 0};
        case (op)
            lslf_pkg::OP_CLEAR:
            begin
                pts = 0;
                acc_x = 0;
                acc_y = 0;
                acc_xx = 0;
                acc_xy = 0;
                pts_dropped = 1'b0;
            end
            lslf_pkg::OP_ACCUM:
            begin
                if (pts >= PTS_CAP)
                begin
                    pts_dropped = 1'b1;
                end
                else
                begin
                    pts++;
                    acc_x += x;
                    acc_y += y;
                    acc_xx += x * x;
                    acc_xy += x * y;
                end
            end
            lslf_pkg::OP_FINISH:
            begin
                n = wide_t'(pts);
                den = n * wide_t'(acc_xx) - wide_t'(acc_x) * wide_t'(acc_x);
                if (pts == 0 || den == 0)
                begin
                    line_degen = 1'b1;
                    line_k = 0;
                    line_b = 0;
                end
                else
                begin
                    kn = (n * wide_t'(acc_xy) - wide_t'(acc_x) * wide_t'(acc_y)) <<< 16;
                    bn = wide_t'(acc_y) * wide_t'(acc_xx) - wide_t'(acc_x) * wide_t'(acc_xy);
                    line_k = div_round_sat(kn, den, -64'sd2147483648, 64'sd2147483647);
                    line_b = div_round_sat(bn, den, -64'sh800000, 64'sh7FFFFF);
                    line_degen = 1'b0;
                end
                res.kind = lslf_pkg::KIND_LINE;
                res.slope = line_k;
                res.intercept = line_b;
                res.degenerate = line_degen;
                res.point_count = pts;
                res.overflowed = pts_dropped;
                expected_fits = {expected_fits, res};
            end
            default:
            begin
                res.kind = lslf_pkg::KIND_POINT;
                res.degenerate = line_degen;
                if (line_degen)
                begin
                    res.fitted_y = y;
                end
                else
                begin
                    res.fitted_y = scale_round_sat24(x * line_k + line_b * 65536);
                end
                expected_fits = {expected_fits, res};
            end
        endcase
    endfunction

    task automatic send_op(lslf_pkg::op_t op, logic [23:0] xc, logic [23:0] yc);
        int gap;
        @(negedge clk);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {yc, xc};
        #1;
        while (!s_tready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        fitter_apply(op, xc, yc);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 2047)) - 24'd1024;
            1: return 24'($urandom);
            2: return 24'($urandom_range(0, 65535)) - 24'd32768;
            default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        endcase
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_fits.size() == 0)
            begin
                $display("%0t unexpected output transaction, expected none, actual %h",
                         $time, m_tdata);
                errors++;
            end
            else
            begin
                automatic fit_result_t e = expected_fits.pop_front();
                check_field("kind", e.kind, m_tuser[0]);
                check_field("slope", e.slope, $signed(m_tdata[31:0]));
                check_field("intercept", e.intercept, $signed(m_tdata[55:32]));
                check_field("degenerate", e.degenerate, m_tdata[56]);
                check_field("point_count", e.point_count, m_tdata[73:57]);
                check_field("overflowed", e.overflowed, m_tdata[74]);
                check_field("fitted_y", e.fitted_y, $signed(m_tdata[98:75]));
                if (e.kind == lslf_pkg::KIND_LINE)
                begin
                    lines_seen++;
                end
                else
                begin
                    points_seen++;
                end
            end
        end
    end

    // receiver: random stall bursts, or a long hold when asked
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else if (!recv_gaps)
            begin
                m_tready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        send_op(lslf_pkg::OP_POINT, 24'h000100, 24'h800000);
        send_op(lslf_pkg::OP_FINISH, 24'h0, 24'h0);
        send_op(lslf_pkg::OP_POINT, 24'h7FFFFF, 24'h7FFFFF);
        send_op(lslf_pkg::OP_ACCUM, 24'h7FFFFF, 24'h800000);
        send_op(lslf_pkg::OP_ACCUM, 24'h800000, 24'h7FFFFF);
        send_op(lslf_pkg::OP_ACCUM, 24'h000000, 24'h000000);
        send_op(lslf_pkg::OP_FINISH, 24'h0, 24'h0);
        send_op(lslf_pkg::OP_POINT, 24'h7FFFFF, 24'h0);
        send_op(lslf_pkg::OP_POINT, 24'h800000, 24'h0);
        send_op(lslf_pkg::OP_POINT, 24'h000000, 24'h0);
        // steep line saturates slope and intercept
        send_op(lslf_pkg::OP_CLEAR, 24'h0, 24'h0);
        send_op(lslf_pkg::OP_ACCUM, 24'h000001, 24'h7FFFFF);
        send_op(lslf_pkg::OP_ACCUM, 24'h000002, 24'h800000);
        send_op(lslf_pkg::OP_FINISH, 24'h0, 24'h0);
        send_op(lslf_pkg::OP_POINT, 24'h000003, 24'h0);
        send_op(lslf_pkg::OP_POINT, 24'h800000, 24'h0);
        // all x equal gives a zero denominator
        send_op(lslf_pkg::OP_CLEAR, 24'h0, 24'h0);
        send_op(lslf_pkg::OP_ACCUM, 24'h000500, 24'h000100);
        send_op(lslf_pkg::OP_ACCUM, 24'h000500, 24'h000900);
        send_op(lslf_pkg::OP_FINISH, 24'h0, 24'h0);
        send_op(lslf_pkg::OP_POINT, 24'h000500, 24'h123456);
        send_op(lslf_pkg::OP_CLEAR, 24'h0, 24'h0);
        send_op(lslf_pkg::OP_FINISH, 24'h0, 24'h0);
    endtask

    task automatic test_backpressure();
        fork
            hold_cycles = 1500;
        join_none
        send_op(lslf_pkg::OP_ACCUM, 24'h000100, 24'h000200);
        send_op(lslf_pkg::OP_ACCUM, 24'h000300, 24'h000100);
        send_op(lslf_pkg::OP_FINISH, 24'h0, 24'h0);
        repeat (4) send_op(lslf_pkg::OP_POINT, rand_coord(), rand_coord());
        send_op(lslf_pkg::OP_FINISH, 24'h0, 24'h0);
    endtask

    task automatic test_random(int n_items);
        int sent;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_op(lslf_pkg::op_t'($urandom_range(0, 3)), rand_coord(), rand_coord());
                sent++;
            end
            else
            begin
                send_op(lslf_pkg::OP_CLEAR, 24'($urandom), 24'($urandom));
                k = $urandom_range(0, 5) == 0 ? $urandom_range(0, 2) : $urandom_range(2, 10);
                repeat (k) send_op(lslf_pkg::OP_ACCUM, rand_coord(), rand_coord());
                send_op(lslf_pkg::OP_FINISH, 24'($urandom), 24'($urandom));
                repeat ($urandom_range(0, 3))
                    send_op(lslf_pkg::OP_POINT, rand_coord(), rand_coord());
                sent += k + 2;
            end
        end
    endtask

    task automatic test_steady_stream();
        send_op(lslf_pkg::OP_CLEAR, 24'h0, 24'h0);
        repeat (6) send_op(lslf_pkg::OP_ACCUM, 24'h800000, rand_coord());
        send_op(lslf_pkg::OP_FINISH, 24'h0, 24'h0);
        send_op(lslf_pkg::OP_POINT, 24'h000100, 24'h654321);
        send_op(lslf_pkg::OP_CLEAR, 24'h0, 24'h0);
        send_op(lslf_pkg::OP_ACCUM, 24'h000100, 24'h000100);
        send_op(lslf_pkg::OP_ACCUM, 24'h000200, 24'h000300);
        send_op(lslf_pkg::OP_FINISH, 24'h0, 24'h0);
        send_op(lslf_pkg::OP_POINT, 24'h7FFFFF, 24'h0);
        send_op(lslf_pkg::OP_CLEAR, 24'h0, 24'h0);
        repeat (8) send_op(lslf_pkg::OP_ACCUM, rand_coord(), rand_coord());
        send_op(lslf_pkg::OP_FINISH, 24'h0, 24'h0);
        repeat (3) send_op(lslf_pkg::OP_POINT, rand_coord(), rand_coord());
    endtask

    initial
    begin
        int drain;
        errors = 0;
        cycles = 0;
        lines_seen = 0;
        points_seen = 0;
        hold_cycles = 0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        rst_n = 1'b0;
        fitter_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random(1800);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        test_steady_stream();

        @(negedge clk);
        s_tvalid = 1'b0;
        drain = 0;
        while (expected_fits.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (600) @(posedge clk);
        $display("checked %0d line results and %0d fitted points", lines_seen, points_seen);
        $display("covered degenerate fits, saturation, back pressure and gapless streams");
        if (errors == 0 && expected_fits.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("%0d results still expected", expected_fits.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/lslf_pkg.sv
rtl/core/lslf_mul.sv
rtl/core/lslf_alu.sv
rtl/core/least_squares_line_fit_unit.sv
tb/tb.sv
